// ----- rtl/sbi_pkg.sv -----
`default_nettype none
package sbi_pkg;

  // field widths
  localparam int COORD_BITS     = 16;
  localparam int TIME_FRAC_BITS = 16;

  // extended coordinate difference, signed
  localparam int EW = COORD_BITS + 2;
  // magnitude of a coordinate difference
  localparam int MW = COORD_BITS + 1;
  // divisor 2*|dir|
  localparam int DW = COORD_BITS + 1;
  // quotient bits kept; larger quotients saturate
  localparam int QB = TIME_FRAC_BITS + 2;
  // dividend 2*|diff|*S + |dir|
  localparam int NW = COORD_BITS + TIME_FRAC_BITS + 3;
  // quotient bits resolved per divider stage
  localparam int DIV_K = 3;
  localparam int DS    = (QB + DIV_K - 1) / DIV_K;
  // signed time width
  localparam int TW = TIME_FRAC_BITS + 3;
  // contact sum o*S + d*t
  localparam int SW = COORD_BITS + TIME_FRAC_BITS + 2;

  // t = 1, and the clamp just past it
  localparam logic [QB-1:0] T_ONE   = QB'(64'd1 << TIME_FRAC_BITS);
  localparam logic [QB-1:0] T_CLAMP = QB'((64'd1 << TIME_FRAC_BITS) + 64'd1);

  // normal codes
  localparam logic [1:0] NRM_ZERO = 2'b00;
  localparam logic [1:0] NRM_POS  = 2'b01;
  localparam logic [1:0] NRM_NEG  = 2'b11;

  // accept edge to the edge that samples the result strobe
  localparam int PIPE_LAT = DS + 7;

  // one divider lane
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] den;
    logic [QB-1:0] quo;
    logic          ovf;
    logic          neg;
  } div_t;

  // per-item data that rides along the divider
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
    logic                         zx;
    logic                         zy;
    logic                         miss;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/segment_box_intersect.sv -----
`default_nettype none
// Segment versus axis-aligned box test by the slab method, in fixed point.
// A word is accepted on every clock edge with start high and busy low, and
// busy is low whenever reset is released, so one test can enter per cycle.
// The result of each word is driven on out_* for one cycle, marked by
// out_valid, after it has passed the input register, stage A, the divider
// pipeline and post 1 to post 4; the receiver cannot stall it. The four
// slab-time dividers resolve DIV_K quotient bits per stage over DS stages.
// On a miss every output field except out_valid is zero.
module segment_box_intersect (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [sbi_pkg::COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [sbi_pkg::COORD_BITS-1:0] in_origin_y,
  input  wire logic signed [sbi_pkg::COORD_BITS-1:0] in_dir_x,
  input  wire logic signed [sbi_pkg::COORD_BITS-1:0] in_dir_y,
  input  wire logic signed [sbi_pkg::COORD_BITS-1:0] in_box_x,
  input  wire logic signed [sbi_pkg::COORD_BITS-1:0] in_box_y,
  input  wire logic        [sbi_pkg::COORD_BITS-2:0] in_box_w,
  input  wire logic        [sbi_pkg::COORD_BITS-2:0] in_box_h,
  output logic                                    out_valid,
  output logic                                    out_hit,
  output logic signed [sbi_pkg::COORD_BITS-1:0]   out_contact_x,
  output logic signed [sbi_pkg::COORD_BITS-1:0]   out_contact_y,
  output logic signed [1:0]                       out_normal_x,
  output logic signed [1:0]                       out_normal_y,
  output logic                                    out_from_inside
);
  import sbi_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int TF = TIME_FRAC_BITS;

  assign busy = ~rst_n;

  // ---------------- input register ----------------
  logic                 v0_r;
  logic signed [CB-1:0] ox0_r, oy0_r, dx0_r, dy0_r, bx0_r, by0_r;
  logic        [CB-2:0] bw0_r, bh0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
    ox0_r <= in_origin_x;
    oy0_r <= in_origin_y;
    dx0_r <= in_dir_x;
    dy0_r <= in_dir_y;
    bx0_r <= in_box_x;
    by0_r <= in_box_y;
    bw0_r <= in_box_w;
    bh0_r <= in_box_h;
  end

  // ---------------- stage A: bound differences and magnitudes ----------------
  function automatic logic signed [EW-1:0] sx(input logic signed [CB-1:0] v);
    sx = {{2{v[CB-1]}}, v};
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] n;
    n = v[EW-1] ? -v : v;
    mag = n[MW-1:0];
  endfunction

  logic signed [EW-1:0] mnx, mxx, mny, mxy, oxe, oye;
  logic signed [EW-1:0] dlx, dhx, dly, dhy;
  logic signed [CB-1:0] adx_s, ady_s;
  logic                 outx, outy;

  always_comb begin
    oxe   = sx(ox0_r);
    oye   = sx(oy0_r);
    mnx   = sx(bx0_r);
    mny   = sx(by0_r);
    mxx   = mnx + {3'b000, bw0_r};
    mxy   = mny + {3'b000, bh0_r};
    dlx   = mnx - oxe;
    dhx   = mxx - oxe;
    dly   = mny - oye;
    dhy   = mxy - oye;
    outx  = (oxe < mnx) || (oxe > mxx);
    outy  = (oye < mny) || (oye > mxy);
    adx_s = dx0_r[CB-1] ? -dx0_r : dx0_r;
    ady_s = dy0_r[CB-1] ? -dy0_r : dy0_r;
  end

  logic          va_r;
  logic [MW-1:0] ma_r [4];
  logic [3:0]    nga_r;
  logic [CB-1:0] adxa_r, adya_r;
  side_t         sda_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= v0_r;
    end
    ma_r[0]      <= mag(dlx);
    ma_r[1]      <= mag(dhx);
    ma_r[2]      <= mag(dly);
    ma_r[3]      <= mag(dhy);
    nga_r        <= {dhy[EW-1] ^ dy0_r[CB-1], dly[EW-1] ^ dy0_r[CB-1],
                     dhx[EW-1] ^ dx0_r[CB-1], dlx[EW-1] ^ dx0_r[CB-1]};
    adxa_r       <= adx_s;
    adya_r       <= ady_s;
    sda_r.ox     <= ox0_r;
    sda_r.oy     <= oy0_r;
    sda_r.dx     <= dx0_r;
    sda_r.dy     <= dy0_r;
    sda_r.zx     <= (dx0_r == '0);
    sda_r.zy     <= (dy0_r == '0);
    sda_r.miss   <= ((dx0_r == '0) && outx) || ((dy0_r == '0) && outy);
  end

  // ---------------- stage B: dividend, divisor, range check ----------------
  div_t dvb [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      logic [CB-1:0] ad;
      ad          = (l < 2) ? adxa_r : adya_r;
      dvb[l].rem  = {1'b0, ma_r[l], {(TF + 1){1'b0}}} + NW'(ad);
      dvb[l].den  = {ad, 1'b0};
      dvb[l].quo  = '0;
      dvb[l].ovf  = dvb[l].rem >= {dvb[l].den, {QB{1'b0}}};
      dvb[l].neg  = nga_r[l];
    end
  end

  // ---------------- divider pipeline ----------------
  function automatic div_t div_step(input div_t x, input int j);
    div_t          y;
    logic [NW-1:0] sh;
    int            i;
    y = x;
    for (int k = 0; k < DIV_K; k++) begin
      i = QB - 1 - j * DIV_K - k;
      if (i >= 0) begin
        sh = NW'(y.den) << i;
        if (y.rem >= sh) begin
          y.rem    = y.rem - sh;
          y.quo[i] = 1'b1;
        end
      end
    end
    div_step = y;
  endfunction

  logic  vd_r  [DS+1];
  div_t  dv_r  [DS+1][4];
  side_t sd_r  [DS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else begin
      vd_r[0] <= va_r;
    end
    for (int l = 0; l < 4; l++) begin
      dv_r[0][l] <= dvb[l];
    end
    sd_r[0] <= sda_r;
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[g+1] <= 1'b0;
      end else begin
        vd_r[g+1] <= vd_r[g];
      end
      for (int l = 0; l < 4; l++) begin
        dv_r[g+1][l] <= div_step(dv_r[g][l], g);
      end
      sd_r[g+1] <= sd_r[g];
    end
  end

  // ---------------- post 1: signed, clamped slab times ----------------
  localparam logic signed [TW-1:0] TC = TW'(T_CLAMP);

  function automatic logic signed [TW-1:0] slab_time(input div_t x);
    logic [QB-1:0] m;
    logic signed [TW-1:0] s;
    m = (x.ovf || (x.quo > T_CLAMP)) ? T_CLAMP : x.quo;
    s = TW'(m);
    slab_time = x.neg ? -s : s;
  endfunction

  logic signed [TW-1:0] tlo [4];
  logic signed [TW-1:0] tnx_nxt, tfx_nxt, tny_nxt, tfy_nxt;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      tlo[l] = slab_time(dv_r[DS][l]);
    end
    tnx_nxt = sd_r[DS].zx ? -TC : ((tlo[0] < tlo[1]) ? tlo[0] : tlo[1]);
    tfx_nxt = sd_r[DS].zx ?  TC : ((tlo[0] < tlo[1]) ? tlo[1] : tlo[0]);
    tny_nxt = sd_r[DS].zy ? -TC : ((tlo[2] < tlo[3]) ? tlo[2] : tlo[3]);
    tfy_nxt = sd_r[DS].zy ?  TC : ((tlo[2] < tlo[3]) ? tlo[3] : tlo[2]);
  end

  logic                 v1_r;
  logic signed [TW-1:0] tnx_r, tfx_r, tny_r, tfy_r;
  side_t                sd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= vd_r[DS];
    end
    tnx_r <= tnx_nxt;
    tfx_r <= tfx_nxt;
    tny_r <= tny_nxt;
    tfy_r <= tfy_nxt;
    sd1_r <= sd_r[DS];
  end

  // ---------------- post 2: choose time and face ----------------
  logic                 entry_x, exit_x, from_in, use_x, hit_c;
  logic signed [TW-1:0] tmin, tmax, tsel;

  always_comb begin
    entry_x = tnx_r >= tny_r;
    tmin    = entry_x ? tnx_r : tny_r;
    exit_x  = tfx_r <= tfy_r;
    tmax    = exit_x ? tfx_r : tfy_r;
    from_in = tmin[TW-1];
    tsel    = from_in ? tmax : tmin;
    use_x   = from_in ? exit_x : entry_x;
    hit_c   = !sd1_r.miss && !(tmax < tmin) && !tsel[TW-1] && (tsel <= TW'(T_ONE));
  end

  logic          v2_r, hit2_r, ins2_r, usex2_r;
  logic [TF:0]   t2_r;
  side_t         sd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    hit2_r  <= hit_c;
    ins2_r  <= from_in;
    usex2_r <= use_x;
    t2_r    <= tsel[TF:0];
    sd2_r   <= sd1_r;
  end

  // ---------------- post 3: contact sums o*S + d*t ----------------
  function automatic logic [1:0] negsign(input logic signed [CB-1:0] d);
    if (d == '0)       negsign = NRM_ZERO;
    else if (d[CB-1])  negsign = NRM_POS;
    else               negsign = NRM_NEG;
  endfunction

  logic signed [TF+1:0] ts;
  logic signed [SW-1:0] prx, pry, px_nxt, py_nxt;

  always_comb begin
    ts     = $signed({1'b0, t2_r});
    prx    = sd2_r.dx * ts;
    pry    = sd2_r.dy * ts;
    px_nxt = prx + {{2{sd2_r.ox[CB-1]}}, sd2_r.ox, {TF{1'b0}}};
    py_nxt = pry + {{2{sd2_r.oy[CB-1]}}, sd2_r.oy, {TF{1'b0}}};
  end

  logic                 v3_r, hit3_r, ins3_r;
  logic signed [SW-1:0] px3_r, py3_r;
  logic [1:0]           nx3_r, ny3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    hit3_r <= hit2_r;
    ins3_r <= ins2_r;
    px3_r  <= px_nxt;
    py3_r  <= py_nxt;
    nx3_r  <= usex2_r ? negsign(sd2_r.dx) : NRM_ZERO;
    ny3_r  <= usex2_r ? NRM_ZERO : negsign(sd2_r.dy);
  end

  // ---------------- post 4: round, saturate, output register ----------------
  localparam int RW = SW - TF;
  localparam logic [RW-1:0] POS_LIM = RW'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic [RW-1:0] NEG_LIM = RW'(64'd1 << (CB - 1));

  function automatic logic signed [CB-1:0] round_sat(input logic signed [SW-1:0] p);
    logic [SW-1:0] a;
    logic [SW-1:0] r;
    logic [RW-1:0] q;
    logic [RW-1:0] qn;
    a = p[SW-1] ? -p : p;
    r = a + SW'(64'd1 << (TF - 1));
    q = r[SW-1:TF];
    if (!p[SW-1]) begin
      round_sat = (q > POS_LIM) ? CB'(POS_LIM) : CB'(q);
    end else if (q > NEG_LIM) begin
      round_sat = CB'(NEG_LIM);
    end else begin
      qn        = -q;
      round_sat = CB'(qn);
    end
  endfunction

  logic                 ov_r, oh_r, oin_r;
  logic signed [CB-1:0] ocx_r, ocy_r;
  logic signed [1:0]    onx_r, ony_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v3_r;
    end
    oh_r  <= hit3_r;
    oin_r <= hit3_r & ins3_r;
    ocx_r <= hit3_r ? round_sat(px3_r) : '0;
    ocy_r <= hit3_r ? round_sat(py3_r) : '0;
    onx_r <= hit3_r ? nx3_r : NRM_ZERO;
    ony_r <= hit3_r ? ny3_r : NRM_ZERO;
  end

  assign out_valid       = ov_r;
  assign out_hit         = oh_r;
  assign out_contact_x   = ocx_r;
  assign out_contact_y   = ocy_r;
  assign out_normal_x    = onx_r;
  assign out_normal_y    = ony_r;
  assign out_from_inside = oin_r;

endmodule
`default_nettype wire

// ----- rtl/sbi_checker.sv -----
`default_nettype none
module sbi_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               out_valid,
  input wire logic                               out_hit,
  input wire logic signed [sbi_pkg::COORD_BITS-1:0] out_contact_x,
  input wire logic signed [sbi_pkg::COORD_BITS-1:0] out_contact_y,
  input wire logic signed [1:0]                  out_normal_x,
  input wire logic signed [1:0]                  out_normal_y,
  input wire logic                               out_from_inside
);
  import sbi_pkg::*;

  // every accepted word gives exactly one result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted word produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without an accepted word");

  // a miss reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_contact_x == '0 && out_contact_y == '0 &&
      out_normal_x == '0 && out_normal_y == '0 && !out_from_inside))
    else $error("miss with nonzero fields");

  // a hit names exactly one face
  a_hit_face: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (((out_normal_x != '0) != (out_normal_y != '0)) &&
      out_normal_x != 2'sb10 && out_normal_y != 2'sb10))
    else $error("hit without a single face normal");

endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_contact_x  (out_contact_x),
  .out_contact_y  (out_contact_y),
  .out_normal_x   (out_normal_x),
  .out_normal_y   (out_normal_y),
  .out_from_inside(out_from_inside)
);
`default_nettype wire
